FILE: sv/imh_pkg.sv
package imh_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int ID_LIMIT   = 2048;

  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int ID_W  = 12;
  localparam int ST_W  = 3;

  // Heap address (position minus one), position/count, stored id (id minus one).
  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int PW    = $clog2(HEAP_DEPTH + 1);
  localparam int IDW   = $clog2(ID_LIMIT);
  localparam int LID_W = $clog2(ID_LIMIT + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELMIN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELID  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOID  = 3'd3;
  localparam logic [ST_W-1:0] ST_NOIDS = 3'd4;

  // One heap entry: its value and the owning insertion number minus one.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [IDW-1:0]          id;
  } entry_t;

endpackage

FILE: sv/indexed_min_heap_core.sv
// Addressable binary min-heap of signed 32-bit values.
// Input channel (in_valid_i / in_stall_o) carries one command beat: insert,
// peek minimum, delete minimum, delete by insertion number, or modify the
// value held by an insertion number. Each accepted beat yields exactly one
// output beat (out_valid_o / out_stall_i) with the minimum, the count and a
// status. Illegal requests (empty, full, ids exhausted, stale id) are
// flagged and leave the state untouched.
// One command is worked on at a time. An insert climbs the heap level by
// level; a delete or modify sifts down and then, if needed, up, on a heap
// of up to 1024 entries. The pace is set by the single read port of the heap
// memory: every level of a sift reads one or two entries through it.
// After reset the heap is empty and no insertion numbers have been given
// out; no clearing pass is needed, since only numbers already handed out are
// ever looked up. A new command is taken while the previous result still
// waits at the output; when the receiver stalls, the finished result holds
// and the block waits before presenting the next one.
module indexed_min_heap_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [imh_pkg::CMD_W-1:0]         command_i,
  input  logic signed [imh_pkg::VAL_W-1:0]  value_i,
  input  logic [imh_pkg::ID_W-1:0]          insertion_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [imh_pkg::VAL_W-1:0]  min_value_o,
  output logic [imh_pkg::PW-1:0]            entry_count_o,
  output logic [imh_pkg::ST_W-1:0]          status_o
);

  import imh_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LOOK  = 11'b00000000010,
    S_DEL_A = 11'b00000000100,
    S_DEL_B = 11'b00000001000,
    S_DN_L  = 11'b00000010000,
    S_DN_R  = 11'b00000100000,
    S_DN_C  = 11'b00001000000,
    S_UP_RD = 11'b00010000000,
    S_UP_C  = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0]    size_q, size_d;
  logic [LID_W-1:0] last_q, last_d;
  logic [PW-1:0]    p_q, p_d;
  entry_t           e_q, e_d;
  entry_t           cl_q, cl_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [IDW-1:0]   idm1_q, idm1_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic signed [VAL_W-1:0] root_q;
  logic             out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] min_q, min_d;
  logic [PW-1:0]    cnt_q, cnt_d;
  logic [ST_W-1:0]  ost_q, ost_d;

  // Heap memory: entry at position p lives at address p-1.
  logic          hp_we, hp_re;
  logic [AW-1:0] hp_waddr, hp_raddr;
  entry_t        hp_wdata, hp_rdata;

  // Position map: insertion number minus one to heap position.
  logic           is_we, is_re;
  logic [IDW-1:0] is_waddr, is_raddr;
  logic [PW-1:0]  is_wdata, is_rdata;

  imh_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (hp_we),
    .waddr_i (hp_waddr),
    .wdata_i (hp_wdata),
    .re_i    (hp_re),
    .raddr_i (hp_raddr),
    .rdata_o (hp_rdata)
  );

  imh_ram #(.WIDTH(PW), .DEPTH(ID_LIMIT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (is_we),
    .waddr_i (is_waddr),
    .wdata_i (is_wdata),
    .re_i    (is_re),
    .raddr_i (is_raddr),
    .rdata_o (is_rdata)
  );

  // Position arithmetic around the current position.
  logic [PW-1:0] pm1, ppos, ppm1, szm1;
  logic [PW:0]   lpos, rpos, lm1, rm1, size_x;
  logic [ID_W-1:0] in_idm1;
  entry_t          cmin;
  logic [PW-1:0]   cpos;

  assign pm1     = p_q - PW'(1);
  assign ppos    = p_q >> 1;
  assign ppm1    = ppos - PW'(1);
  assign szm1    = size_q - PW'(1);
  assign lpos    = {p_q, 1'b0};
  assign rpos    = {p_q, 1'b1};
  assign lm1     = lpos - (PW+1)'(1);
  assign rm1     = rpos - (PW+1)'(1);
  assign size_x  = {1'b0, size_q};
  assign in_idm1 = insertion_id_i - ID_W'(1);

  // Smaller child; the right one wins only when strictly smaller.
  always_comb begin
    if ($signed(hp_rdata.val) < $signed(cl_q.val)) begin
      cmin = hp_rdata;
      cpos = rpos[PW-1:0];
    end else begin
      cmin = cl_q;
      cpos = lpos[PW-1:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    last_d      = last_q;
    p_d         = p_q;
    e_d         = e_q;
    cl_d        = cl_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    idm1_d      = idm1_q;
    st_d        = st_q;
    min_d       = min_q;
    cnt_d       = cnt_q;
    ost_d       = ost_q;
    out_valid_d = out_valid_q && out_stall_i;

    hp_we    = 1'b0;
    hp_waddr = '0;
    hp_wdata = '0;
    hp_re    = 1'b0;
    hp_raddr = '0;
    is_we    = 1'b0;
    is_waddr = '0;
    is_wdata = '0;
    is_re    = 1'b0;
    is_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          val_d  = value_i;
          idm1_d = in_idm1[IDW-1:0];
          st_d   = ST_OK;
          unique case (command_i) inside
            CMD_INSERT: begin
              if (32'(size_q) >= HEAP_DEPTH) begin
                st_d    = ST_FULL;
                state_d = S_RESP;
              end else if (32'(last_q) >= ID_LIMIT) begin
                st_d    = ST_NOIDS;
                state_d = S_RESP;
              end else begin
                size_d  = size_q + PW'(1);
                last_d  = last_q + LID_W'(1);
                e_d.val = value_i;
                e_d.id  = last_q[IDW-1:0];
                p_d     = size_q + PW'(1);
                state_d = S_UP_RD;
              end
            end
            CMD_DELMIN: begin
              if (size_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                p_d      = PW'(1);
                hp_re    = 1'b1;
                hp_raddr = '0;
                state_d  = S_DEL_A;
              end
            end
            CMD_DELID, CMD_MODIFY: begin
              if (insertion_id_i == '0 || 32'(insertion_id_i) > 32'(last_q)) begin
                st_d    = ST_NOID;
                state_d = S_RESP;
              end else begin
                is_re    = 1'b1;
                is_raddr = in_idm1[IDW-1:0];
                state_d  = S_LOOK;
              end
            end
            default: begin
              st_d    = (size_q == '0) ? ST_EMPTY : ST_OK;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (is_rdata == '0 || is_rdata > size_q) begin
          st_d    = ST_NOID;
          state_d = S_RESP;
        end else begin
          p_d = is_rdata;
          if (cmd_q == CMD_MODIFY) begin
            e_d.val = val_q;
            e_d.id  = idm1_q;
            state_d = S_DN_L;
          end else begin
            hp_re    = 1'b1;
            hp_raddr = AW'(is_rdata - PW'(1));
            state_d  = S_DEL_A;
          end
        end
      end
      S_DEL_A: begin
        // The victim's insertion number becomes absent; fetch the last entry.
        is_we    = 1'b1;
        is_waddr = hp_rdata.id;
        is_wdata = '0;
        hp_re    = 1'b1;
        hp_raddr = szm1[AW-1:0];
        state_d  = S_DEL_B;
      end
      S_DEL_B: begin
        e_d    = hp_rdata;
        size_d = szm1;
        state_d = (p_q != size_q) ? S_DN_L : S_RESP;
      end
      S_DN_L: begin
        if (lpos > size_x) begin
          state_d = S_UP_RD;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = lm1[AW-1:0];
          state_d  = S_DN_R;
        end
      end
      S_DN_R: begin
        cl_d = hp_rdata;
        if (rpos <= size_x) begin
          hp_re    = 1'b1;
          hp_raddr = rm1[AW-1:0];
          state_d  = S_DN_C;
        end else if ($signed(hp_rdata.val) < $signed(e_q.val)) begin
          hp_we    = 1'b1;
          hp_waddr = pm1[AW-1:0];
          hp_wdata = hp_rdata;
          is_we    = 1'b1;
          is_waddr = hp_rdata.id;
          is_wdata = p_q;
          p_d      = lpos[PW-1:0];
          state_d  = S_DN_L;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_DN_C: begin
        if ($signed(cmin.val) < $signed(e_q.val)) begin
          hp_we    = 1'b1;
          hp_waddr = pm1[AW-1:0];
          hp_wdata = cmin;
          is_we    = 1'b1;
          is_waddr = cmin.id;
          is_wdata = p_q;
          p_d      = cpos;
          state_d  = S_DN_L;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (p_q == PW'(1)) begin
          state_d = S_FIN;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = ppm1[AW-1:0];
          state_d  = S_UP_C;
        end
      end
      S_UP_C: begin
        if ($signed(e_q.val) < $signed(hp_rdata.val)) begin
          hp_we    = 1'b1;
          hp_waddr = pm1[AW-1:0];
          hp_wdata = hp_rdata;
          is_we    = 1'b1;
          is_waddr = hp_rdata.id;
          is_wdata = p_q;
          p_d      = ppos;
          state_d  = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // The travelling entry settles into the hole.
        hp_we    = 1'b1;
        hp_waddr = pm1[AW-1:0];
        hp_wdata = e_q;
        is_we    = 1'b1;
        is_waddr = e_q.id;
        is_wdata = p_q;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          min_d       = (size_q != '0) ? root_q : '0;
          cnt_d       = size_q;
          ost_d       = st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; the root copy follows every write to position one.
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    e_q    <= e_d;
    cl_q   <= cl_d;
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    idm1_q <= idm1_d;
    st_q   <= st_d;
    min_q  <= min_d;
    cnt_q  <= cnt_d;
    ost_q  <= ost_d;
    if (hp_we && hp_waddr == '0) begin
      root_q <= hp_wdata.val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_value_o   = min_q;
  assign entry_count_o = cnt_q;
  assign status_o      = ost_q;

endmodule

FILE: sv/imh_ram.sv
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: tb/imh_checker.sv
module imh_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [imh_pkg::CMD_W-1:0]         command_i,
  input  logic signed [imh_pkg::VAL_W-1:0]  value_i,
  input  logic [imh_pkg::ID_W-1:0]          insertion_id_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [imh_pkg::VAL_W-1:0]  min_value_i,
  input  logic [imh_pkg::PW-1:0]            entry_count_i,
  input  logic [imh_pkg::ST_W-1:0]          status_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  import imh_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic [PW-1:0]           entry_count;
    logic [ST_W-1:0]         status;
  } heap_answer_t;

  // Shadow heap, positions 1..shadow_size, root at 1.
  logic signed [VAL_W-1:0] shadow_val [1:HEAP_DEPTH];
  int                      shadow_owner [1:HEAP_DEPTH];
  int                      id_position [0:ID_LIMIT];
  int                      shadow_size;
  int                      ids_given;
  heap_answer_t            answer_queue [$];

  assign pending_o = answer_queue.size();

  function automatic void swap_slots(int a, int b);
    logic signed [VAL_W-1:0] tv;
    int                      ta;
    ta = shadow_owner[a];
    id_position[ta] = b;
    id_position[shadow_owner[b]] = a;
    shadow_owner[a] = shadow_owner[b];
    shadow_owner[b] = ta;
    tv = shadow_val[a];
    shadow_val[a] = shadow_val[b];
    shadow_val[b] = tv;
  endfunction

  function automatic void settle_at(int p);
    int best;
    int q;
    q = p;
    forever begin
      best = q;
      if (2*q <= shadow_size && shadow_val[2*q] < shadow_val[best]) best = 2*q;
      if (2*q+1 <= shadow_size && shadow_val[2*q+1] < shadow_val[best]) best = 2*q+1;
      if (best == q) break;
      swap_slots(q, best);
      q = best;
    end
    // After the downward pass, let the entry climb if it is now too small.
    while (q > 1 && shadow_val[q] < shadow_val[q/2]) begin
      swap_slots(q/2, q);
      q = q/2;
    end
  endfunction

  function automatic void drop_slot(int p);
    swap_slots(p, shadow_size);
    id_position[shadow_owner[shadow_size]] = 0;
    shadow_size--;
    if (p <= shadow_size) settle_at(p);
  endfunction

  function automatic int find_slot(int id);
    if (id == 0 || id > ID_LIMIT || id > ids_given) return 0;
    return id_position[id];
  endfunction

  function automatic heap_answer_t apply_command(logic [CMD_W-1:0] cmd,
                                                 logic signed [VAL_W-1:0] v, int id);
    heap_answer_t a;
    int p;
    a.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_size >= HEAP_DEPTH) a.status = ST_FULL;
        else if (ids_given >= ID_LIMIT) a.status = ST_NOIDS;
        else begin
          shadow_size++;
          ids_given++;
          shadow_val[shadow_size] = v;
          shadow_owner[shadow_size] = ids_given;
          id_position[ids_given] = shadow_size;
          settle_at(shadow_size);
        end
      end
      CMD_DELMIN: begin
        if (shadow_size == 0) a.status = ST_EMPTY;
        else drop_slot(1);
      end
      CMD_DELID, CMD_MODIFY: begin
        p = find_slot(id);
        if (p == 0 || p > shadow_size) a.status = ST_NOID;
        else if (cmd == CMD_DELID) drop_slot(p);
        else begin
          shadow_val[p] = v;
          settle_at(p);
        end
      end
      default: if (shadow_size == 0) a.status = ST_EMPTY;
    endcase
    a.min_value = shadow_size > 0 ? shadow_val[1] : '0;
    a.entry_count = PW'(shadow_size);
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("checker: %s got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    shadow_size = 0;
    ids_given = 0;
    foreach (id_position[i]) id_position[i] = 0;
  end

  always @(posedge clk_i) begin
    heap_answer_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_queue.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          want = answer_queue.pop_front();
          if (min_value_i !== want.min_value)
            report_mismatch("min_value", min_value_i, want.min_value);
          if (entry_count_i !== want.entry_count)
            report_mismatch("entry_count", entry_count_i, want.entry_count);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
        end
      end
      if (in_valid_i && !in_stall_i)
        answer_queue.push_back(apply_command(command_i, value_i, int'(insertion_id_i)));
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import imh_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        command_i;
  logic signed [VAL_W-1:0] value_i;
  logic [ID_W-1:0]         insertion_id_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] min_value_o;
  logic [PW-1:0]           entry_count_o;
  logic [ST_W-1:0]         status_o;
  int                      fail_count;
  int                      pending;

  // Sender and receiver idling switch off for the closing part of the run.
  bit quiet_phase;
  bit hold_receiver;
  int ids_issued;

  indexed_min_heap_core dut (.*);

  imh_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .value_i,
    .insertion_id_i, .out_valid_i(out_valid_o), .out_stall_i, .min_value_i(min_value_o),
    .entry_count_i(entry_count_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Sends one command beat and holds it until it is taken.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v, int id);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    value_i <= v;
    insertion_id_i <= id[ID_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == CMD_INSERT) ids_issued++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Mostly live ids, sometimes stale or out of range ones.
  function automatic int pick_id();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 4095);
      1: return 0;
      default: return ids_issued == 0 ? 1 : $urandom_range(ids_issued > 40 ? ids_issued - 40 : 1,
                                                          ids_issued);
    endcase
  endfunction

  // Random command mix; insert_bias sets the weight of inserts in percent.
  task automatic random_beat(int insert_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_bias) send_beat(CMD_INSERT, pick_value(), pick_id());
    else if (r < insert_bias + 8) send_beat(CMD_PEEK, pick_value(), pick_id());
    else if (r < insert_bias + 22) send_beat(CMD_DELMIN, pick_value(), pick_id());
    else if (r < insert_bias + 38) send_beat(CMD_DELID, pick_value(), pick_id());
    else if (r < 98) send_beat(CMD_MODIFY, pick_value(), pick_id());
    else send_beat(3'($urandom_range(5, 7)), pick_value(), pick_id());
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the quiet phase.
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_receiver) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_receiver);
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int k;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_PEEK;
    value_i = '0;
    insertion_id_i = '0;
    quiet_phase = 1'b0;
    hold_receiver = 1'b0;
    ids_issued = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty heap cases, extremes, stale ids, undefined codes.
    send_beat(CMD_PEEK, 0, 0);
    send_beat(CMD_DELMIN, 0, 0);
    send_beat(CMD_DELID, 0, 1);
    send_beat(CMD_MODIFY, 5, 1);
    send_beat(3'd7, 0, 0);
    send_beat(CMD_INSERT, 32'sh7fff_ffff, 0);
    send_beat(CMD_INSERT, 32'sh8000_0000, 0);
    send_beat(CMD_INSERT, 0, 0);
    send_beat(CMD_INSERT, -1, 0);
    send_beat(CMD_PEEK, 0, 0);
    send_beat(3'd5, 0, 0);
    send_beat(CMD_MODIFY, 32'sh7fff_ffff, 2);
    send_beat(CMD_DELID, 0, 4);
    send_beat(CMD_DELID, 0, 4);
    send_beat(CMD_MODIFY, 1, 4095);
    send_beat(CMD_DELID, 0, 2048);
    send_beat(CMD_DELMIN, 0, 0);
    send_beat(3'd6, 0, 0);
    send_beat(CMD_DELID, 0, 3);
    send_beat(CMD_DELMIN, 0, 0);
    send_beat(CMD_DELMIN, 0, 0);

    // Random mix while the receiver holds off for a long stretch.
    hold_receiver = 1'b1;
    for (k = 0; k < 60; k++) random_beat(50);
    hold_receiver = 1'b0;

    for (k = 0; k < 100; k++) random_beat(k < 50 ? 45 : 30);

    // Fill to the top so that the full-heap path is hit.
    for (k = 0; k < HEAP_DEPTH + 4; k++) send_beat(CMD_INSERT, pick_value(), 0);

    quiet_phase = 1'b1;
    for (k = 0; k < 40; k++) random_beat(20);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("indexed_min_heap_core: match");
    else $display("indexed_min_heap_core: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("indexed_min_heap_core: mismatch");
    $finish;
  end

endmodule
